// ----- sv/amr_pkg.sv -----
package amr_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] coord_a_x;
    logic signed [31:0] coord_a_y;
    logic signed [31:0] coord_a_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic signed [31:0] coord_c_x;
    logic signed [31:0] coord_c_y;
    logic signed [31:0] coord_c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic        [2:0]  axis_blocked;
    logic               table_full;
  } out_item_t;

  // One stored box: index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

  typedef struct packed {
    logic we;
    logic rot;
  } cell_ctrl_t;

endpackage

// ----- sv/amr_cell.sv -----
module amr_cell
  import amr_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  box_t       wdata_i,
  input  box_t       nbr_i,
  output box_t       box_o
);

  box_t box_q;

  // A write stores a new box; a rotation takes the neighbour's box.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      box_q <= wdata_i;
    end else if (ctrl_i.rot) begin
      box_q <= nbr_i;
    end
  end

  assign box_o = box_q;

endmodule

// ----- sv/aabb_movement_restrainer_core.sv -----
// Movement restrainer against a table of static axis-aligned boxes.
// Input channel: an item is accepted at a rising edge of clk_i where start_i
// is high and busy_o is low. An add item (action 0) stores one box in the
// next free cell of the box ring, or sets table_full if the ring is full; a
// query item (action 1) moves a position by a velocity and cancels the axes
// on which the moved object box runs into a stored box.
// Output channel: every item gives exactly one result on res_o, shown for a
// single cycle with res_strobe_o high. The receiver cannot stall, so the
// result must be taken in that cycle.
// An add item's result appears in the cycle after it is accepted, and
// busy_o never rises, so items can follow back to back.
// A query item keeps busy_o high while the object box is formed (ST_PREP)
// and while the ring of box cells rotates once round (ST_SCAN), one stored
// box passing the shared comparator per cycle. The result appears in the
// cycle busy_o falls, and a new item may be accepted in that same cycle.
// Reset (rst_ni low, asynchronous) empties the table and abandons any query
// in progress; the box cells themselves are not cleared, since only cells
// below the fill count are ever tested.
module aabb_movement_restrainer_core
  import amr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  output logic      busy_o,
  output logic      res_strobe_o,
  output out_item_t res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             strobe_q, strobe_d;
  out_item_t        res_q, res_d;
  logic [2:0]       blocked_q, blocked_d;

  // Query operands held for the whole scan.
  logic signed [31:0] pos_q   [3];
  logic signed [32:0] moved_q [3];
  logic signed [31:0] half_q  [3];
  logic        [2:0]  vneg_q;
  logic signed [33:0] omin_q  [3];
  logic signed [33:0] omax_q  [3];

  logic accept;
  logic table_has_room;
  logic is_add;

  box_t       box [MAX_BOXES];
  box_t       wbox;
  cell_ctrl_t cell_ctrl [MAX_BOXES];

  assign accept         = start_i && !busy_o;
  assign is_add         = (item_i.action == ACT_ADD);
  assign table_has_room = (count_q < CNT_W'(MAX_BOXES));

  assign wbox.lo = {item_i.coord_a_z, item_i.coord_a_y, item_i.coord_a_x};
  assign wbox.hi = {item_i.coord_c_z, item_i.coord_c_y, item_i.coord_c_x};

  // The ring of box cells: cell i takes the box of cell i+1 on a rotation,
  // so after k rotations cell 0 holds the box stored at entry k. A full
  // turn of MAX_BOXES rotations brings every box back to its own cell.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    assign cell_ctrl[i].we  = accept && is_add && table_has_room &&
                              (count_q == CNT_W'(i));
    assign cell_ctrl[i].rot = (state_q == ST_SCAN);

    amr_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .wdata_i (wbox),
      .nbr_i   (box[(i + 1) % MAX_BOXES]),
      .box_o   (box[i])
    );
  end

  // Comparator on the head of the ring.
  logic signed [33:0] blo [3];
  logic signed [33:0] bhi [3];
  logic signed [34:0] diff [3];
  logic        [2:0]  axis_hit;
  logic        [2:0]  dir_differs;
  logic               entry_live;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      blo[ax]         = 34'(signed'(box[0].lo[ax]));
      bhi[ax]         = 34'(signed'(box[0].hi[ax]));
      axis_hit[ax]    = (omin_q[ax] <= bhi[ax]) && (omax_q[ax] >= blo[ax]);
      diff[ax]        = 35'(omax_q[ax]) - 35'(bhi[ax]);
      dir_differs[ax] = vneg_q[ax] != diff[ax][34];
    end
  end

  assign entry_live = (CNT_W'(step_q) < count_q);

  // A moved coordinate beyond the 32-bit range saturates to the limit.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    count_d   = count_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    blocked_d = blocked_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_add) begin
            strobe_d = 1'b1;
            res_d    = '0;
            if (table_has_room) begin
              count_d = count_q + CNT_W'(1);
            end else begin
              res_d.table_full = 1'b1;
            end
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        blocked_d = '0;
        step_d    = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (entry_live && (&axis_hit)) begin
          blocked_d = blocked_q | dir_differs;
        end
        if (step_q == IDX_W'(MAX_BOXES - 1)) begin
          state_d            = ST_IDLE;
          strobe_d           = 1'b1;
          res_d.new_pos_x    = blocked_d[0] ? pos_q[0] : sat32(moved_q[0]);
          res_d.new_pos_y    = blocked_d[1] ? pos_q[1] : sat32(moved_q[1]);
          res_d.new_pos_z    = blocked_d[2] ? pos_q[2] : sat32(moved_q[2]);
          res_d.axis_blocked = blocked_d;
          res_d.table_full   = 1'b0;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      count_q   <= '0;
      strobe_q  <= 1'b0;
      blocked_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      count_q   <= count_d;
      strobe_q  <= strobe_d;
      blocked_q <= blocked_d;
    end
  end

  // Query operands: the moved point and half size at acceptance, the object
  // box in state ST_PREP.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept && !is_add) begin
      pos_q[0]   <= item_i.coord_a_x;
      pos_q[1]   <= item_i.coord_a_y;
      pos_q[2]   <= item_i.coord_a_z;
      moved_q[0] <= 33'(item_i.coord_a_x) + 33'(item_i.velocity_x);
      moved_q[1] <= 33'(item_i.coord_a_y) + 33'(item_i.velocity_y);
      moved_q[2] <= 33'(item_i.coord_a_z) + 33'(item_i.velocity_z);
      half_q[0]  <= item_i.coord_c_x >>> 1;
      half_q[1]  <= item_i.coord_c_y >>> 1;
      half_q[2]  <= item_i.coord_c_z >>> 1;
      vneg_q     <= {item_i.velocity_z[31], item_i.velocity_y[31],
                     item_i.velocity_x[31]};
    end
    if (state_q == ST_PREP) begin
      for (int ax = 0; ax < 3; ax++) begin
        omin_q[ax] <= 34'(moved_q[ax]) - 34'(half_q[ax]);
        omax_q[ax] <= 34'(moved_q[ax]) + 34'(half_q[ax]);
      end
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ----- sv/amr_checker.sv -----
module amr_checker
  import amr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input in_item_t  item_i,
  input logic      busy_o,
  input logic      res_strobe_o,
  input out_item_t res_o
);

  // An accepted query holds the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.action == ACT_QUERY) |=> busy_o)
    else $error("query item accepted but block not busy");

  // An accepted add item is answered in the following cycle.
  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.action == ACT_ADD) |=> res_strobe_o)
    else $error("add item not answered in the next cycle");

  // The end of a query shows its result.
  a_query_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_strobe_o)
    else $error("query finished without a result");

  // A dropped box reports nothing but the full flag.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.table_full) |->
      (res_o.axis_blocked == 3'd0 && res_o.new_pos_x == 32'sd0 &&
       res_o.new_pos_y == 32'sd0 && res_o.new_pos_z == 32'sd0))
    else $error("table full result carries other fields");

endmodule

bind aabb_movement_restrainer_core amr_checker u_amr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .item_i       (item_i),
  .busy_o       (busy_o),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
